@@ src/vosc_pkg.sv @@
// Shared constants, types and helpers for the voxel surface classifier.
`default_nettype none

package vosc_pkg;

    localparam int MAX_X = 32;
    localparam int MAX_Y = 32;
    localparam int MAX_Z = 32;

    localparam int CW  = 5;     // cell index field width
    localparam int SW  = 6;     // size register width
    localparam int VW  = 16;    // voxel value width
    localparam int FW  = 3;     // exposed face count width
    localparam int AW  = $clog2(MAX_X * MAX_Y * MAX_Z);
    localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;

    localparam int NB_LAST = 5; // six face neighbours, counted 0..5
    localparam int NCW = 3;

    // neighbour select codes
    localparam logic [NCW-1:0] NB_XM = 3'd0;
    localparam logic [NCW-1:0] NB_XP = 3'd1;
    localparam logic [NCW-1:0] NB_YM = 3'd2;
    localparam logic [NCW-1:0] NB_YP = 3'd3;
    localparam logic [NCW-1:0] NB_ZM = 3'd4;
    localparam logic [NCW-1:0] NB_ZP = 3'd5;

    // request types
    localparam logic REQ_WRITE    = 1'b0;
    localparam logic REQ_CLASSIFY = 1'b1;

    // register indexes
    localparam logic [1:0] REG_THRESH = 2'd0;
    localparam logic [1:0] REG_SIZE_X = 2'd1;
    localparam logic [1:0] REG_SIZE_Y = 2'd2;
    localparam logic [1:0] REG_SIZE_Z = 2'd3;

    typedef struct packed {
        logic capture;      // latch the input transfer
        logic mem_we;       // store the voxel value
        logic eval_center;  // judge the center cell read data
        logic nb_read;      // issue one neighbour read
        logic load_out;     // move the result into the output register
    } t_cmd;

    typedef struct packed {
        logic req_type;
        logic bad;          // index out of range
        logic go_nb;        // occupied, interior: neighbours needed
        logic nb_last;      // last neighbour read being issued
    } t_sts;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                                input logic [CW-1:0] y,
                                                input logic [CW-1:0] z);
        return AW'(x) + AW'(MAX_X) * (AW'(y) + AW'(MAX_Y) * AW'(z));
    endfunction

    function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] s,
                                                 input logic [SW-1:0] lim);
        return (s > lim) ? lim : s;
    endfunction

endpackage

`default_nettype wire

@@ src/vosc_ctrl.sv @@
// Controller state machine for the voxel surface classifier.
`default_nettype none

module vosc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire vosc_pkg::t_sts i_sts,
    output vosc_pkg::t_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_EVC   = 3'd2;
    localparam logic [2:0] S_NB    = 3'd3;
    localparam logic [2:0] S_TAIL  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_START;
                end
            end
            S_START: begin
                // center read is issued here in all cases
                if (i_sts.req_type == vosc_pkg::REQ_WRITE) begin
                    o_cmd.mem_we = !i_sts.bad;
                    n_state = S_DONE;
                end else if (i_sts.bad) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_EVC;
                end
            end
            S_EVC: begin
                o_cmd.eval_center = 1'b1;
                n_state = i_sts.go_nb ? S_NB : S_DONE;
            end
            S_NB: begin
                o_cmd.nb_read = 1'b1;
                if (i_sts.nb_last) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a pending result");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_START))
        else $error("accepted transfer did not start work");

    a_nb_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NB && i_sts.nb_last) |=> (r_state == S_TAIL))
        else $error("neighbour sweep did not end after last read");

    a_write_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mem_we |-> (r_state == S_START && !i_sts.bad))
        else $error("memory write outside start state or with bad index");

endmodule

`default_nettype wire

@@ src/vosc_dp.sv @@
// Datapath: item registers, voxel memory, face counter, result register.
`default_nettype none

module vosc_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire vosc_pkg::t_cmd                i_cmd,
    output vosc_pkg::t_sts                     o_sts,
    input  wire logic signed [vosc_pkg::VW-1:0] i_thresh,
    input  wire logic [vosc_pkg::SW-1:0]       i_size_x,
    input  wire logic [vosc_pkg::SW-1:0]       i_size_y,
    input  wire logic [vosc_pkg::SW-1:0]       i_size_z,
    input  wire logic                          i_req_type,
    input  wire logic [vosc_pkg::CW-1:0]       i_cell_x,
    input  wire logic [vosc_pkg::CW-1:0]       i_cell_y,
    input  wire logic [vosc_pkg::CW-1:0]       i_cell_z,
    input  wire logic signed [vosc_pkg::VW-1:0] i_voxel_value,
    output logic                               o_occupied,
    output logic                               o_on_surface,
    output logic [vosc_pkg::FW-1:0]            o_exposed_faces,
    output logic                               o_index_error
);

    logic [vosc_pkg::VW-1:0] mem [vosc_pkg::DEPTH];

    logic                        r_req;
    logic [vosc_pkg::CW-1:0]     r_x, r_y, r_z;
    logic [vosc_pkg::VW-1:0]     r_val;
    logic                        r_bad, r_border;
    logic                        r_occ;
    logic [vosc_pkg::FW-1:0]     r_faces;
    logic [vosc_pkg::NCW-1:0]    r_cnt;
    logic                        r_nb_pend;
    logic signed [vosc_pkg::VW-1:0] r_rdata;

    logic [vosc_pkg::SW-1:0]     m, n, p;
    logic                        bad, border, occ;
    logic [vosc_pkg::CW-1:0]     nx, ny, nz;
    logic [vosc_pkg::AW-1:0]     addr;

    assign m = vosc_pkg::clamp_size(i_size_x, vosc_pkg::SW'(vosc_pkg::MAX_X));
    assign n = vosc_pkg::clamp_size(i_size_y, vosc_pkg::SW'(vosc_pkg::MAX_Y));
    assign p = vosc_pkg::clamp_size(i_size_z, vosc_pkg::SW'(vosc_pkg::MAX_Z));

    assign bad = !(vosc_pkg::SW'(i_cell_x) < m && vosc_pkg::SW'(i_cell_y) < n &&
                   vosc_pkg::SW'(i_cell_z) < p);

    assign border = (i_cell_x == '0) || (vosc_pkg::SW'(i_cell_x) + 1'b1 >= m) ||
                    (i_cell_y == '0) || (vosc_pkg::SW'(i_cell_y) + 1'b1 >= n) ||
                    (i_cell_z == '0) || (vosc_pkg::SW'(i_cell_z) + 1'b1 >= p);

    assign occ = r_rdata > i_thresh;

    // neighbour coordinates; no wrap, interior cells only
    always_comb begin
        nx = r_x;
        ny = r_y;
        nz = r_z;
        case (r_cnt)
            vosc_pkg::NB_XM: nx = r_x - 1'b1;
            vosc_pkg::NB_XP: nx = r_x + 1'b1;
            vosc_pkg::NB_YM: ny = r_y - 1'b1;
            vosc_pkg::NB_YP: ny = r_y + 1'b1;
            vosc_pkg::NB_ZM: nz = r_z - 1'b1;
            vosc_pkg::NB_ZP: nz = r_z + 1'b1;
            default: ;
        endcase
    end

    assign addr = i_cmd.nb_read ? vosc_pkg::cell_addr(nx, ny, nz)
                                : vosc_pkg::cell_addr(r_x, r_y, r_z);

    assign o_sts.req_type = r_req;
    assign o_sts.bad      = r_bad;
    assign o_sts.go_nb    = occ && !r_border;
    assign o_sts.nb_last  = (r_cnt == vosc_pkg::NCW'(vosc_pkg::NB_LAST));

    // single-port voxel memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            mem[addr] <= r_val;
        end
        r_rdata <= mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nb_pend <= 1'b0;
        end else begin
            r_nb_pend <= i_cmd.nb_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req    <= i_req_type;
            r_x      <= i_cell_x;
            r_y      <= i_cell_y;
            r_z      <= i_cell_z;
            r_val    <= i_voxel_value;
            r_bad    <= bad;
            r_border <= border;
            r_occ    <= 1'b0;
            r_faces  <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_cmd.eval_center) begin
                r_occ   <= occ;
                r_faces <= (occ && r_border) ? vosc_pkg::FW'(1) : '0;
            end
            if (i_cmd.nb_read) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_nb_pend && (r_rdata <= i_thresh)) begin
                r_faces <= r_faces + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_occupied      <= r_occ;
            o_on_surface    <= (r_faces != '0);
            o_exposed_faces <= r_faces;
            o_index_error   <= r_bad;
        end
    end

endmodule

`default_nettype wire

@@ src/voxel_occupancy_surface_classifier.sv @@
// Top level: APB register file, controller and datapath of the voxel classifier.
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  ---------------------------------------
//  request   in         i_in_valid / o_in_ready    req_type, cell_x/y/z, voxel_value
//  result    out        o_out_valid / i_out_ready  occupied, on_surface, exposed_faces,
//                                                  index_error
//  config    in         psel, penable, pwrite      paddr, pwdata, prdata (pready tied high)
//
// Operation: one item at a time. A classify of an interior occupied cell reads the
//   single-port voxel memory once for the center and once for each of six neighbours.
// Reset: synchronous, active low; clears control state and the registers (threshold 0,
//   sizes 32). The voxel memory is not cleared; a cell reads valid only once written.
// Stalls: a finished result waits in the output register; the next request is taken
//   meanwhile and only its own completion waits for the result to be transferred.
`default_nettype none

module voxel_occupancy_surface_classifier (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_req_type,
    input  wire logic [vosc_pkg::CW-1:0]       i_cell_x,
    input  wire logic [vosc_pkg::CW-1:0]       i_cell_y,
    input  wire logic [vosc_pkg::CW-1:0]       i_cell_z,
    input  wire logic signed [vosc_pkg::VW-1:0] i_voxel_value,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_occupied,
    output logic                               o_on_surface,
    output logic [vosc_pkg::FW-1:0]            o_exposed_faces,
    output logic                               o_index_error,
    // APB configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [3:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic signed [vosc_pkg::VW-1:0] r_thresh;
    logic [vosc_pkg::SW-1:0]        r_size_x, r_size_y, r_size_z;
    logic                           cfg_wr;
    logic [1:0]                     reg_idx;

    vosc_pkg::t_cmd cmd;
    vosc_pkg::t_sts sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    // register write lands on the access phase
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= '0;
            r_size_x <= vosc_pkg::SW'(vosc_pkg::MAX_X);
            r_size_y <= vosc_pkg::SW'(vosc_pkg::MAX_Y);
            r_size_z <= vosc_pkg::SW'(vosc_pkg::MAX_Z);
        end else if (cfg_wr) begin
            case (reg_idx)
                vosc_pkg::REG_THRESH: r_thresh <= pwdata[vosc_pkg::VW-1:0];
                vosc_pkg::REG_SIZE_X: r_size_x <= pwdata[vosc_pkg::SW-1:0];
                vosc_pkg::REG_SIZE_Y: r_size_y <= pwdata[vosc_pkg::SW-1:0];
                vosc_pkg::REG_SIZE_Z: r_size_z <= pwdata[vosc_pkg::SW-1:0];
                default: ;
            endcase
        end
    end

    // read-back, zero extended
    always_comb begin
        case (reg_idx)
            vosc_pkg::REG_THRESH: prdata = 32'(unsigned'(r_thresh));
            vosc_pkg::REG_SIZE_X: prdata = 32'(r_size_x);
            vosc_pkg::REG_SIZE_Y: prdata = 32'(r_size_y);
            vosc_pkg::REG_SIZE_Z: prdata = 32'(r_size_z);
            default:              prdata = '0;
        endcase
    end

    vosc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    vosc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_thresh        (r_thresh),
        .i_size_x        (r_size_x),
        .i_size_y        (r_size_y),
        .i_size_z        (r_size_z),
        .i_req_type      (i_req_type),
        .i_cell_x        (i_cell_x),
        .i_cell_y        (i_cell_y),
        .i_cell_z        (i_cell_z),
        .i_voxel_value   (i_voxel_value),
        .o_occupied      (o_occupied),
        .o_on_surface    (o_on_surface),
        .o_exposed_faces (o_exposed_faces),
        .o_index_error   (o_index_error)
    );

endmodule

`default_nettype wire

@@ bench/tb_voxel_occupancy_surface_classifier.sv @@
// Self-checking bench for the voxel occupancy surface classifier.
`default_nettype none

module tb_voxel_occupancy_surface_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    import vosc_pkg::*;

    // ------------------------------------------------------------------
    // Types
    // ------------------------------------------------------------------
    typedef struct packed {
        logic                 req_type;
        logic [CW-1:0]        cell_x;
        logic [CW-1:0]        cell_y;
        logic [CW-1:0]        cell_z;
        logic signed [VW-1:0] voxel_value;
    } voxel_req_t;

    typedef struct packed {
        logic          occupied;
        logic          on_surface;
        logic [FW-1:0] exposed_faces;
        logic          index_error;
    } cell_report_t;

    // directed script: either one request transfer or one register write
    typedef enum logic {STEP_ITEM, STEP_REG} step_kind_t;

    typedef struct {
        step_kind_t   kind;
        voxel_req_t   req;
        logic [1:0]   reg_idx;
        logic [31:0]  reg_val;
        bit           typed;    // want holds a hand-written expectation
        cell_report_t want;
    } script_row_t;

    localparam int LONG_HOLD   = 300;   // receiver back-pressure burst, in cycles
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 112;   // counted requests per random phase

    // idling mixes, cycled over the random phases
    int send_pct_of [4] = '{0, 74, 0, 36};
    int recv_pct_of [4] = '{0, 0, 74, 36};

    // ------------------------------------------------------------------
    // DUT signals, all inputs at known values from time zero
    // ------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_req_type = REQ_WRITE;
    logic [CW-1:0]        i_cell_x = '0;
    logic [CW-1:0]        i_cell_y = '0;
    logic [CW-1:0]        i_cell_z = '0;
    logic signed [VW-1:0] i_voxel_value = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_occupied;
    logic                 o_on_surface;
    logic [FW-1:0]        o_exposed_faces;
    logic                 o_index_error;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [3:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    always #2 i_clk = ~i_clk;

    voxel_occupancy_surface_classifier dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_cell_x        (i_cell_x),
        .i_cell_y        (i_cell_y),
        .i_cell_z        (i_cell_z),
        .i_voxel_value   (i_voxel_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_occupied      (o_occupied),
        .o_on_surface    (o_on_surface),
        .o_exposed_faces (o_exposed_faces),
        .o_index_error   (o_index_error),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // ------------------------------------------------------------------
    // Shadow of the block: registers, voxel grid, and which cells hold data.
    // The grid is addressed with the full 32x32x32 geometry so a size change
    // never moves a stored value.
    // ------------------------------------------------------------------
    logic signed [VW-1:0] thr_q = '0;
    logic [SW-1:0]        size_x_q = 6'd32;
    logic [SW-1:0]        size_y_q = 6'd32;
    logic [SW-1:0]        size_z_q = 6'd32;
    logic signed [VW-1:0] voxel_mem [0:DEPTH-1];
    bit                   cell_written [0:DEPTH-1];

    cell_report_t cell_reports_due [$];   // one entry per accepted request, oldest first

    int fail_count   = 0;
    int n_requests   = 0;
    int n_classify   = 0;
    int n_interior   = 0;
    int n_surface    = 0;
    int n_index_err  = 0;
    int n_results    = 0;
    int n_reg_writes = 0;

    // stimulus knobs
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int unsigned hold_requests  = 0;   // bumped by the stimulus to ask for a long hold
    int unsigned holds_served   = 0;
    int unsigned hold_left      = 0;
    int          box_lo [3];
    int          box_hi [3];

    // sizes above the grid dimension saturate; zero leaves no valid index
    function automatic int axis_cells(logic [SW-1:0] s, int dim);
        return (int'(s) > dim) ? dim : int'(s);
    endfunction

    function automatic bit in_grid(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
        return int'(x) < axis_cells(size_x_q, MAX_X) && int'(y) < axis_cells(size_y_q, MAX_Y)
            && int'(z) < axis_cells(size_z_q, MAX_Z);
    endfunction

    function automatic bit on_border(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
        return x == '0 || int'(x) + 1 >= axis_cells(size_x_q, MAX_X)
            || y == '0 || int'(y) + 1 >= axis_cells(size_y_q, MAX_Y)
            || z == '0 || int'(z) + 1 >= axis_cells(size_z_q, MAX_Z);
    endfunction

    function automatic int voxel_index(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
        return int'({z, y, x});
    endfunction

    function automatic int neighbor_index(logic [CW-1:0] x, logic [CW-1:0] y,
                                          logic [CW-1:0] z, logic [NCW-1:0] side);
        case (side)
            NB_XM:   return voxel_index(x - 1'b1, y, z);
            NB_XP:   return voxel_index(x + 1'b1, y, z);
            NB_YM:   return voxel_index(x, y - 1'b1, z);
            NB_YP:   return voxel_index(x, y + 1'b1, z);
            NB_ZM:   return voxel_index(x, y, z - 1'b1);
            NB_ZP:   return voxel_index(x, y, z + 1'b1);
            default: return voxel_index(x, y, z);
        endcase
    endfunction

    // Works out the report for one accepted request and applies any write.
    function automatic cell_report_t cell_report_for(voxel_req_t r);
        cell_report_t rep;
        int a;
        rep = '0;
        if (!in_grid(r.cell_x, r.cell_y, r.cell_z)) begin
            // out-of-range writes are dropped, classifies read nothing
            rep.index_error = 1'b1;
            n_index_err++;
            return rep;
        end
        a = voxel_index(r.cell_x, r.cell_y, r.cell_z);
        if (r.req_type == REQ_WRITE) begin
            voxel_mem[a] = r.voxel_value;
            cell_written[a] = 1'b1;
            return rep;
        end
        n_classify++;
        if (voxel_mem[a] <= thr_q)
            return rep;
        rep.occupied = 1'b1;
        if (on_border(r.cell_x, r.cell_y, r.cell_z)) begin
            // border cell: one surface entry, neighbours not looked at
            rep.exposed_faces = FW'(1);
        end else begin
            n_interior++;
            for (int k = 0; k <= NB_LAST; k++) begin
                if (voxel_mem[neighbor_index(r.cell_x, r.cell_y, r.cell_z, NCW'(k))] <= thr_q)
                    rep.exposed_faces = rep.exposed_faces + 1'b1;
            end
        end
        rep.on_surface = (rep.exposed_faces != '0);
        if (rep.on_surface)
            n_surface++;
        return rep;
    endfunction

    // Index of a never-written cell that a classify here would read, else -1.
    function automatic int unread_cell(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
        int a;
        int nb;
        if (!in_grid(x, y, z))
            return -1;
        a = voxel_index(x, y, z);
        if (!cell_written[a])
            return a;
        if (voxel_mem[a] <= thr_q || on_border(x, y, z))
            return -1;
        for (int k = 0; k <= NB_LAST; k++) begin
            nb = neighbor_index(x, y, z, NCW'(k));
            if (!cell_written[nb])
                return nb;
        end
        return -1;
    endfunction

    // Half of the values lie within two LSBs of the threshold, so occupancy flips often.
    function automatic logic signed [VW-1:0] rand_value();
        int v;
        case ($urandom_range(3))
            0, 1: begin
                v = int'(thr_q) + int'($urandom_range(4)) - 2;
                if (v > 32767)
                    v = 32767;
                if (v < -32768)
                    v = -32768;
                return VW'(v);
            end
            2:       return VW'($urandom);
            default: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        endcase
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: ready pattern and the scoreboard
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        cell_report_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (cell_reports_due.size() == 0) begin
                fail_count++;
                $display("%0t ns: result transfer with nothing outstanding", $time);
            end else begin
                want = cell_reports_due.pop_front();
                check_field("occupied", int'(want.occupied), int'(o_occupied));
                check_field("on_surface", int'(want.on_surface), int'(o_on_surface));
                check_field("exposed_faces", int'(want.exposed_faces), int'(o_exposed_faces));
                check_field("index_error", int'(want.index_error), int'(o_index_error));
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Holds valid until the transfer, then queues what the block should answer.
    // A typed expectation replaces the shadow's answer, the shadow still updates.
    task automatic offer_request(input voxel_req_t r, input bit typed, input cell_report_t want);
        cell_report_t model;
        i_in_valid    <= 1'b1;
        i_req_type    <= r.req_type;
        i_cell_x      <= r.cell_x;
        i_cell_y      <= r.cell_y;
        i_cell_z      <= r.cell_z;
        i_voxel_value <= r.voxel_value;
        do @(posedge i_clk); while (!o_in_ready);
        n_requests++;
        model = cell_report_for(r);
        cell_reports_due.insert(cell_reports_due.size(), typed ? want : model);
    endtask

    // Random idle gap after a transfer; valid drops only if a gap is taken.
    task automatic sender_pause();
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Block is idle once every accepted request has produced its result.
    task automatic drain_requests();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (cell_reports_due.size() != 0)
            @(posedge i_clk);
    endtask

    // One APB transfer: setup, access (pready tied high), then the bus goes idle.
    task automatic apb_access(input bit wr, input logic [1:0] idx, input logic [31:0] data,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] rd;
        logic [31:0] mask;
        apb_access(1'b1, idx, val, rd);
        n_reg_writes++;
        case (idx)
            REG_THRESH: thr_q    = val[VW-1:0];
            REG_SIZE_X: size_x_q = val[SW-1:0];
            REG_SIZE_Y: size_y_q = val[SW-1:0];
            REG_SIZE_Z: size_z_q = val[SW-1:0];
            default: ;
        endcase
        // readback: only the implemented bits are compared
        mask = (idx == REG_THRESH) ? 32'h0000_FFFF : 32'h0000_003F;
        apb_access(1'b0, idx, '0, rd);
        check_field("register readback", int'(val & mask), int'(rd & mask));
    endtask

    // New threshold and sizes for a random phase, plus a small working box.
    task automatic configure_random_phase();
        int s;
        logic [1:0] idx;
        case ($urandom_range(3))
            0:       write_register(REG_THRESH, 32'd0);
            1:       write_register(REG_THRESH, {16'd0, 16'($urandom)});
            2:       write_register(REG_THRESH, 32'(int'($urandom_range(512)) - 256));
            default: write_register(REG_THRESH, $urandom_range(1) ? 32'h7FFF : 32'h8000);
        endcase
        for (int ax = 0; ax < 3; ax++) begin
            case ($urandom_range(5))
                0:       s = 1;
                1:       s = 32;
                default: s = $urandom_range(6, 2);
            endcase
            idx = (ax == 0) ? REG_SIZE_X : (ax == 1) ? REG_SIZE_Y : REG_SIZE_Z;
            write_register(idx, 32'(s));
            // large axes get a window of at most 6 cells so the box fills up quickly
            box_lo[ax] = (s > 6) ? $urandom_range(s - 1) : 0;
            box_hi[ax] = (box_lo[ax] + 5 < s - 1) ? box_lo[ax] + 5 : s - 1;
        end
    endtask

    // Mostly writes and classifies inside the box; a tenth anywhere in the
    // index space. A classify that would read an unwritten cell becomes a
    // write of that cell, so the box fills in around interior classifies.
    task automatic pick_request(output voxel_req_t r);
        int a;
        r.req_type = ($urandom_range(99) < 40) ? REQ_WRITE : REQ_CLASSIFY;
        if ($urandom_range(99) < 10) begin
            r.cell_x = CW'($urandom);
            r.cell_y = CW'($urandom);
            r.cell_z = CW'($urandom);
        end else begin
            r.cell_x = CW'($urandom_range(box_hi[0], box_lo[0]));
            r.cell_y = CW'($urandom_range(box_hi[1], box_lo[1]));
            r.cell_z = CW'($urandom_range(box_hi[2], box_lo[2]));
        end
        r.voxel_value = rand_value();
        if (r.req_type == REQ_CLASSIFY) begin
            a = unread_cell(r.cell_x, r.cell_y, r.cell_z);
            if (a >= 0) begin
                r.req_type = REQ_WRITE;
                r.cell_x = a[4:0];
                r.cell_y = a[9:5];
                r.cell_z = a[14:10];
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Directed script rows
    // ------------------------------------------------------------------
    function automatic script_row_t item_row(logic rt, int x, int y, int z, int v);
        script_row_t row;
        row.kind = STEP_ITEM;
        row.req.req_type = rt;
        row.req.cell_x = CW'(x);
        row.req.cell_y = CW'(y);
        row.req.cell_z = CW'(z);
        row.req.voxel_value = VW'(v);
        row.reg_idx = REG_THRESH;
        row.reg_val = '0;
        row.typed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic script_row_t known_row(logic rt, int x, int y, int z, int v,
                                              bit occ, bit surf, int faces, bit err);
        script_row_t row;
        row = item_row(rt, x, y, z, v);
        row.typed = 1'b1;
        row.want.occupied = occ;
        row.want.on_surface = surf;
        row.want.exposed_faces = FW'(faces);
        row.want.index_error = err;
        return row;
    endfunction

    function automatic script_row_t reg_row(logic [1:0] idx, logic [31:0] val);
        script_row_t row;
        row = item_row(REQ_WRITE, 0, 0, 0, 0);
        row.kind = STEP_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    script_row_t test_script [$];

    // appends one row to the end of the directed script
    function automatic void add_row(script_row_t row);
        test_script.insert(test_script.size(), row);
    endfunction

    initial begin
        // reset values: threshold 0, all sizes 32
        // corner cells at the value extremes
        add_row(known_row(REQ_WRITE,     0, 0, 0, 32767, 0, 0, 0, 0));
        add_row(known_row(REQ_CLASSIFY,  0, 0, 0, 0,     1, 1, 1, 0));
        add_row(known_row(REQ_WRITE,    31,31,31, -32768, 0, 0, 0, 0));
        add_row(known_row(REQ_CLASSIFY, 31,31,31, 0,     0, 0, 0, 0));
        // interior cell (1,1,1): three neighbours at or below the threshold
        add_row(item_row(REQ_WRITE, 1, 1, 1, 256));
        add_row(item_row(REQ_WRITE, 0, 1, 1, 0));
        add_row(item_row(REQ_WRITE, 2, 1, 1, 1));
        add_row(item_row(REQ_WRITE, 1, 0, 1, -1));
        add_row(item_row(REQ_WRITE, 1, 2, 1, 32767));
        add_row(item_row(REQ_WRITE, 1, 1, 0, -32768));
        add_row(item_row(REQ_WRITE, 1, 1, 2, 5));
        add_row(item_row(REQ_CLASSIFY, 1, 1, 1, 0));
        // fill the empty neighbours: occupied but fully enclosed
        add_row(item_row(REQ_WRITE, 0, 1, 1, 512));
        add_row(item_row(REQ_WRITE, 1, 0, 1, 768));
        add_row(item_row(REQ_WRITE, 1, 1, 0, 1));
        add_row(item_row(REQ_CLASSIFY, 1, 1, 1, -1));
        // threshold at the top: nothing can exceed it
        add_row(reg_row(REG_THRESH, 32'h0000_7FFF));
        add_row(known_row(REQ_CLASSIFY,  0, 0, 0, 0, 0, 0, 0, 0));
        // threshold at the bottom: the most negative value is still empty
        add_row(reg_row(REG_THRESH, 32'h0000_8000));
        add_row(known_row(REQ_CLASSIFY, 31,31,31, 0, 0, 0, 0, 0));
        // zero size: every index out of range, write dropped
        add_row(reg_row(REG_SIZE_X, 32'd0));
        add_row(known_row(REQ_WRITE,     0, 0, 0, 4660, 0, 0, 0, 1));
        add_row(known_row(REQ_CLASSIFY,  0, 0, 0, 0,    0, 0, 0, 1));
        // oversize x saturates, thin y/z slab
        add_row(reg_row(REG_SIZE_X, 32'd63));
        add_row(reg_row(REG_SIZE_Y, 32'd2));
        add_row(reg_row(REG_SIZE_Z, 32'd1));
        add_row(known_row(REQ_CLASSIFY,  0, 0, 0, 0,    1, 1, 1, 0));
        add_row(known_row(REQ_CLASSIFY,  0, 2, 0, 0,    0, 0, 0, 1));
        add_row(known_row(REQ_WRITE,     5, 5, 5, 4660, 0, 0, 0, 1));
        // x size 2: cell (1,1,1) becomes a border cell
        add_row(reg_row(REG_SIZE_X, 32'd2));
        add_row(reg_row(REG_SIZE_Y, 32'd32));
        add_row(reg_row(REG_SIZE_Z, 32'd32));
        add_row(reg_row(REG_THRESH, 32'd0));
        add_row(known_row(REQ_CLASSIFY,  1, 1, 1, 0,    1, 1, 1, 0));
        add_row(known_row(REQ_CLASSIFY, 31,31,31, 0,    0, 0, 0, 1));
        add_row(item_row(REQ_CLASSIFY, 0, 1, 1, 0));
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        voxel_req_t r;
        int done;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows, back to back with no idling
        foreach (test_script[i]) begin
            if (test_script[i].kind == STEP_REG) begin
                drain_requests();
                write_register(test_script[i].reg_idx, test_script[i].reg_val);
            end else begin
                offer_request(test_script[i].req, test_script[i].typed, test_script[i].want);
            end
        end
        drain_requests();

        // random phases: fresh registers each phase, idling mix rotates
        for (int ph = 0; ph < PHASES; ph++) begin
            send_idle_pct = send_pct_of[ph % 4];
            recv_stall_pct <= recv_pct_of[ph % 4];
            configure_random_phase();
            // full-rate sender against a stalled receiver: the block backs up
            if (ph == 4)
                hold_requests <= hold_requests + 1;
            done = 0;
            while (done < PHASE_ITEMS) begin
                pick_request(r);
                offer_request(r, 1'b0, '0);
                // dropped out-of-range writes do not count
                if (r.req_type == REQ_CLASSIFY || in_grid(r.cell_x, r.cell_y, r.cell_z))
                    done++;
                sender_pause();
            end
            drain_requests();
        end

        // let any stray result show up
        repeat (24) @(posedge i_clk);

        $display("Covered %0d requests and %0d register writes over %0d random phases.",
                 n_requests, n_reg_writes, PHASES);
        $display("Classified %0d cells: %0d interior, %0d on the surface; %0d index errors.",
                 n_classify, n_interior, n_surface, n_index_err);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d check(s) failed", fail_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Watchdog expired with %0d result(s) outstanding", cell_reports_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
